/* design/isd_pkg.sv */
// Package of the IMU step detector: field widths, register indexes, reset values,
// item structs and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package isd_pkg;

  localparam int unsigned TIME_W      = 27;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned STEP_IDX_W  = 24;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned REM_W       = 18;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 27;
  localparam int unsigned INDEX_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME  = 3'd6;

  localparam logic signed [AXIS_W-1:0] ACCEL_MIN_RST = -16'sd32768;
  localparam logic signed [AXIS_W-1:0] ACCEL_MAX_RST = 16'sd32767;
  localparam logic signed [AXIS_W-1:0] GYRO_MIN_RST  = -16'sd32000;
  localparam logic signed [AXIS_W-1:0] GYRO_MAX_RST  = 16'sd32000;
  localparam logic [MAG_W-1:0]         STEP_THR_RST  = 16'd2458;
  localparam logic [15:0]              MIN_GAP_RST   = 16'd200;
  localparam logic [TIME_W-1:0]        MAX_TIME_RST  = 27'd84600000;

  typedef struct packed {
    logic                     start_of_run;
    logic [TIME_W-1:0]        sample_time_ms;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [MAG_W-1:0]      magnitude;
    logic                  step_found;
    logic [STEP_IDX_W-1:0] step_index;
    logic [TIME_W-1:0]     step_time_ms;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       root_init;
    logic       root_step;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic ok;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/isd_stream_if.sv */
// Valid/ready channel used for the sample input and the result output.
// The payload type is set per instance from the structs in isd_pkg.
`default_nettype none

interface isd_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/isd_ctrl.sv */
// Controller of the IMU step detector: sequences load, the three squares,
// the sixteen root steps and the result write; a rejected sample skips squares and root. Depends on isd_pkg.
`default_nettype none

module isd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire isd_pkg::dp_status_t status_i,
  output isd_pkg::ctl_cmd_t       cmd_o
);
  import isd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [3:0] LAST_SQ   = 4'd2;
  localparam logic [3:0] LAST_ROOT = 4'd15;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        if (!status_i.ok) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = cnt_q[1:0];
          cnt_d         = cnt_q + 4'd1;
          if (cnt_q == LAST_SQ) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == LAST_ROOT) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* design/isd_datapath.sv */
// Datapath of the IMU step detector: configuration registers, range check,
// shared squarer, bit-serial square root, valley history and result register.
// Depends on isd_pkg.
`default_nettype none

module isd_datapath #(
  parameter int unsigned INDEX_BITS = isd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [isd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [isd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire isd_pkg::in_item_t                    in_data_i,
  input  wire isd_pkg::ctl_cmd_t                    cmd_i,
  output isd_pkg::dp_status_t                       status_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output isd_pkg::out_item_t                        out_data_o
);
  import isd_pkg::*;

  function automatic logic in_range(input logic signed [AXIS_W-1:0] v,
                                    input logic signed [AXIS_W-1:0] lo,
                                    input logic signed [AXIS_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  logic signed [AXIS_W-1:0] accel_min_q, accel_max_q, gyro_min_q, gyro_max_q;
  logic [MAG_W-1:0]         step_thr_q;
  logic [15:0]              min_gap_q;
  logic [TIME_W-1:0]        max_time_q;

  logic [TIME_W-1:0]        time_q;
  logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;
  logic                     ok_q, ok_d;

  logic signed [AXIS_W-1:0] mul_op;
  logic signed [SUM_W-1:0]  sq;
  logic [SUM_W-1:0]         sum_q;

  logic [SUM_W-1:0]         n_q;
  logic [REM_W-1:0]         rem_q;
  logic [MAG_W-1:0]         root_q;
  logic [REM_W+1:0]         rem_sh, trial;
  logic                     ge;

  logic [MAG_W-1:0]         omag_q, cmag_q;
  logic [TIME_W-1:0]        ctime_q, ref_q;
  logic [INDEX_BITS-1:0]    kept_q;
  logic [1:0]               fill_q;

  logic [TIME_W:0]          gap;
  logic                     step;
  logic [INDEX_BITS-1:0]    idx_m1;
  logic [STEP_IDX_W+INDEX_BITS-1:0] idx_ext;

  logic                     out_valid_q;
  out_item_t                out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_min_q <= ACCEL_MIN_RST;
      accel_max_q <= ACCEL_MAX_RST;
      gyro_min_q  <= GYRO_MIN_RST;
      gyro_max_q  <= GYRO_MAX_RST;
      step_thr_q  <= STEP_THR_RST;
      min_gap_q   <= MIN_GAP_RST;
      max_time_q  <= MAX_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACCEL_MIN: accel_min_q <= cfg_data_i[AXIS_W-1:0];
        CFG_ACCEL_MAX: accel_max_q <= cfg_data_i[AXIS_W-1:0];
        CFG_GYRO_MIN:  gyro_min_q  <= cfg_data_i[AXIS_W-1:0];
        CFG_GYRO_MAX:  gyro_max_q  <= cfg_data_i[AXIS_W-1:0];
        CFG_STEP_THR:  step_thr_q  <= cfg_data_i[MAG_W-1:0];
        CFG_MIN_GAP:   min_gap_q   <= cfg_data_i[15:0];
        CFG_MAX_TIME:  max_time_q  <= cfg_data_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ok_d = (in_data_i.sample_time_ms <= max_time_q) &&
                in_range(in_data_i.accel_x, accel_min_q, accel_max_q) &&
                in_range(in_data_i.accel_y, accel_min_q, accel_max_q) &&
                in_range(in_data_i.accel_z, accel_min_q, accel_max_q) &&
                in_range(in_data_i.gyro_x, gyro_min_q, gyro_max_q) &&
                in_range(in_data_i.gyro_y, gyro_min_q, gyro_max_q) &&
                in_range(in_data_i.gyro_z, gyro_min_q, gyro_max_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      time_q <= in_data_i.sample_time_ms;
      ax_q   <= in_data_i.accel_x;
      ay_q   <= in_data_i.accel_y;
      az_q   <= in_data_i.accel_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      ok_q <= ok_d;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      2'd0:    mul_op = ax_q;
      2'd1:    mul_op = ay_q;
      default: mul_op = az_q;
    endcase
  end

  assign sq = mul_op * mul_op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (cmd_i.mul_en) begin
      sum_q <= sum_q + SUM_W'($unsigned(sq));
    end
  end

  assign rem_sh = {rem_q, n_q[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      n_q    <= sum_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      n_q    <= {n_q[SUM_W-3:0], 2'b00};
      rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[MAG_W-2:0], ge};
    end
  end

  assign gap    = {1'b0, ctime_q} - {1'b0, ref_q};
  assign step   = ok_q && fill_q[1] && (cmag_q < omag_q) && (root_q > cmag_q) &&
                  (cmag_q <= step_thr_q) &&
                  ($signed(gap) > $signed({{(TIME_W - 15){1'b0}}, min_gap_q}));
  assign idx_m1  = kept_q - INDEX_BITS'(1);
  assign idx_ext = {{STEP_IDX_W{1'b0}}, idx_m1};

  always_comb begin
    out_d = '0;
    if (ok_q) begin
      out_d.accepted  = 1'b1;
      out_d.magnitude = root_q;
      if (step) begin
        out_d.step_found   = 1'b1;
        out_d.step_index   = idx_ext[STEP_IDX_W-1:0];
        out_d.step_time_ms = ctime_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omag_q  <= '0;
      cmag_q  <= '0;
      ctime_q <= '0;
      ref_q   <= '0;
      kept_q  <= '0;
      fill_q  <= '0;
    end else if (cmd_i.load && in_data_i.start_of_run) begin
      omag_q  <= '0;
      cmag_q  <= '0;
      ctime_q <= '0;
      ref_q   <= '0;
      kept_q  <= '0;
      fill_q  <= '0;
    end else if (cmd_i.finish && ok_q) begin
      if (step) begin
        ref_q <= ctime_q;
      end else if (fill_q == 2'd0) begin
        ref_q <= time_q;
      end
      omag_q  <= cmag_q;
      cmag_q  <= root_q;
      ctime_q <= time_q;
      kept_q  <= kept_q + INDEX_BITS'(1);
      if (!fill_q[1]) begin
        fill_q <= fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign status_o.ok       = ok_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

/* design/imu_step_detector_top.sv */
// Top level of the IMU step detector: one controller and one datapath behind
// valid/ready channels. Depends on isd_pkg, isd_stream_if, isd_ctrl, isd_datapath.
//
// Each sample is one transaction on in_if and gives exactly one result
// transaction on out_if. A sample that passes the range checks is loaded, then
// each accelerometer axis is squared on the single shared 16x16 squarer, the
// root is set up, the bit-serial square root is worked out, and a final step
// updates the valley history and writes the result. A rejected sample goes
// from the load straight to that final step, which stretches for as long as
// an unread result still holds the output register. The next sample is taken
// as soon as its predecessor's result is in the output register, even while
// out_if stalls. Configuration must be written by the user through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no sample is in flight; the block itself
// does not enforce this. Unknown indexes are ignored.
`default_nettype none

module imu_step_detector_top #(
  parameter int unsigned INDEX_BITS = isd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [isd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [isd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  isd_stream_if.sink                          in_if,
  isd_stream_if.source                        out_if
);
  import isd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_data;
  in_item_t   in_data;

  assign in_data = in_if.data;

  isd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isd_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

endmodule

`default_nettype wire

/* tb/sv/isd_step_checker.sv */
// Checker for the IMU step detector: watches the configuration port and both
// channels, predicts one result per accepted sample and compares it field by field.
// Depends on isd_pkg.
module isd_step_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [isd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [isd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  isd_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  isd_pkg::out_item_t             out_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import isd_pkg::*;

  logic signed [AXIS_W-1:0] accel_lo, accel_hi, gyro_lo, gyro_hi;
  logic [MAG_W-1:0]         valley_thr;
  logic [15:0]              gap_ms;
  logic [TIME_W-1:0]        time_limit;

  logic [MAG_W-1:0]      older_mag, center_mag;
  logic [TIME_W-1:0]     center_time, ref_time;
  logic [STEP_IDX_W-1:0] kept;
  logic [1:0]            fill;

  out_item_t predicted_results[$];

  function automatic logic in_bounds(input logic signed [AXIS_W-1:0] v, lo, hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [MAG_W-1:0] floor_root(input longint n);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (longint'(trial) * longint'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  task automatic clear_history();
    older_mag = '0;
    center_mag = '0;
    center_time = '0;
    ref_time = '0;
    kept = '0;
    fill = '0;
  endtask

  task automatic predict_step_result(input in_item_t s, output out_item_t r);
    logic             keep;
    logic [MAG_W-1:0] mag;
    longint           energy;
    longint           gap;
    r = '0;
    if (s.start_of_run) clear_history();
    keep = (s.sample_time_ms <= time_limit) &&
           in_bounds(s.accel_x, accel_lo, accel_hi) &&
           in_bounds(s.accel_y, accel_lo, accel_hi) &&
           in_bounds(s.accel_z, accel_lo, accel_hi) &&
           in_bounds(s.gyro_x, gyro_lo, gyro_hi) &&
           in_bounds(s.gyro_y, gyro_lo, gyro_hi) &&
           in_bounds(s.gyro_z, gyro_lo, gyro_hi);
    if (keep) begin
      energy = longint'(s.accel_x) * longint'(s.accel_x) +
               longint'(s.accel_y) * longint'(s.accel_y) +
               longint'(s.accel_z) * longint'(s.accel_z);
      mag = floor_root(energy);
      r.accepted = 1'b1;
      r.magnitude = mag;
      if (fill >= 2'd2) begin
        gap = longint'(center_time) - longint'(ref_time);
        if (center_mag < older_mag && mag > center_mag && center_mag <= valley_thr &&
            gap > longint'(gap_ms)) begin
          r.step_found = 1'b1;
          r.step_index = kept - 1'b1;
          r.step_time_ms = center_time;
          ref_time = center_time;
        end
      end
      if (fill == 2'd0) ref_time = s.sample_time_ms;
      older_mag = center_mag;
      center_mag = mag;
      center_time = s.sample_time_ms;
      if (fill < 2'd2) fill = fill + 1'b1;
      kept = kept + 1'b1;
    end
  endtask

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      accel_lo = ACCEL_MIN_RST;
      accel_hi = ACCEL_MAX_RST;
      gyro_lo = GYRO_MIN_RST;
      gyro_hi = GYRO_MAX_RST;
      valley_thr = STEP_THR_RST;
      gap_ms = MIN_GAP_RST;
      time_limit = MAX_TIME_RST;
      clear_history();
      predicted_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_MIN: accel_lo = cfg_data_i[AXIS_W-1:0];
          CFG_ACCEL_MAX: accel_hi = cfg_data_i[AXIS_W-1:0];
          CFG_GYRO_MIN:  gyro_lo = cfg_data_i[AXIS_W-1:0];
          CFG_GYRO_MAX:  gyro_hi = cfg_data_i[AXIS_W-1:0];
          CFG_STEP_THR:  valley_thr = cfg_data_i[MAG_W-1:0];
          CFG_MIN_GAP:   gap_ms = cfg_data_i[15:0];
          CFG_MAX_TIME:  time_limit = cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction with no sample outstanding");
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("accepted", want.accepted, out_data_i.accepted);
          compare_field("magnitude", want.magnitude, out_data_i.magnitude);
          compare_field("step_found", want.step_found, out_data_i.step_found);
          compare_field("step_index", want.step_index, out_data_i.step_index);
          compare_field("step_time_ms", want.step_time_ms, out_data_i.step_time_ms);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_step_result(in_data_i, want);
        predicted_results = {predicted_results, want};
      end
    end
    pending_o = predicted_results.size();
  end

endmodule

/* tb/sv/tb_imu_step_detector_top.sv */
// Testbench top for the IMU step detector: clock, reset, configuration writes,
// directed and random sample streams with random idling, and the verdict.
// Depends on isd_pkg, isd_stream_if, imu_step_detector_top and isd_step_checker.
module tb_imu_step_detector_top;
  import isd_pkg::*;

  localparam int unsigned RUN_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned SEG_COUNT = 6;
  localparam int unsigned SEG_ITEMS = 100;
  localparam int unsigned NUM_SETTINGS = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned cycles = 0;

  logic [CFG_DATA_W-1:0] setting_val [NUM_SETTINGS];
  logic [TIME_W-1:0]     walk_time;
  in_item_t              directed_q[$];

  isd_stream_if #(.payload_t(in_item_t))  sample_ch ();
  isd_stream_if #(.payload_t(out_item_t)) result_ch ();

  imu_step_detector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (sample_ch),
    .out_if     (result_ch)
  );

  isd_step_checker u_step_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (sample_ch.valid),
    .in_ready_i   (sample_ch.ready),
    .in_data_i    (sample_ch.data),
    .out_valid_i  (result_ch.valid),
    .out_ready_i  (result_ch.ready),
    .out_data_i   (result_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("imu_step_detector_top: mismatch");
      $finish;
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic in_item_t make_sample(input logic sor, input int t, input int ax,
                                           input int ay, input int az, input int gx,
                                           input int gy, input int gz);
    in_item_t s;
    s.start_of_run = sor;
    s.sample_time_ms = TIME_W'(t);
    s.accel_x = AXIS_W'(ax);
    s.accel_y = AXIS_W'(ay);
    s.accel_z = AXIS_W'(az);
    s.gyro_x = AXIS_W'(gx);
    s.gyro_y = AXIS_W'(gy);
    s.gyro_z = AXIS_W'(gz);
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] as_reg(input int v);
    return v[CFG_DATA_W-1:0];
  endfunction

  task automatic add_directed(input in_item_t s);
    directed_q = {directed_q, s};
  endtask

  task automatic send_sample(input in_item_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
  endtask

  task automatic write_settings();
    for (int i = 0; i < NUM_SETTINGS; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_data <= setting_val[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b1;
    cfg_idx <= CFG_NONE;
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t     s;
    int unsigned  r;
    int           lvl;
    logic [127:0] noise;
    sample_ch.valid <= 1'b0;
    sample_ch.data <= '0;
    src_idle_pct = 20;
    sink_stall_pct = 84;
    walk_time = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes of the fields and the range bounds under the reset settings.
    add_directed(make_sample(1, 0, -32768, -32768, -32768, 0, 0, 0));
    add_directed(make_sample(0, 10, 32767, 32767, 32767, 0, 0, 0));
    add_directed(make_sample(0, 20, 0, 0, 3000, -32768, 0, 0));
    add_directed(make_sample(0, 30, 0, 0, 3000, 0, 32000, -32000));
    add_directed(make_sample(0, 40, 0, 0, 3000, 0, 0, 32001));
    add_directed(make_sample(0, 84600000, 0, 0, 0, 0, 0, 0));
    add_directed(make_sample(0, 84600001, 0, 0, 0, 0, 0, 0));
    add_directed(make_sample(0, 134217727, 0, 0, 0, 32767, 32767, 32767));
    // Valleys: a step, a gap exactly at the minimum, a valley at the threshold,
    // one just above it, a rejected sample inside the history, an equal pair,
    // time going backwards, and a new run with too little history.
    add_directed(make_sample(1, 1000, 0, 0, 2048, 0, 0, 0));
    add_directed(make_sample(0, 1100, 0, 0, 3000, 0, 0, 0));
    add_directed(make_sample(0, 1300, 0, 0, 1500, 0, 0, 0));
    add_directed(make_sample(0, 1400, 0, 0, 3000, 0, 0, 0));
    add_directed(make_sample(0, 1500, 0, 0, 1000, 0, 0, 0));
    add_directed(make_sample(0, 1600, 0, 0, 3000, 0, 0, 0));
    add_directed(make_sample(0, 1700, 0, 0, 2458, 0, 0, 0));
    add_directed(make_sample(0, 1800, -1000, 0, 3000, 0, 0, 0));
    add_directed(make_sample(0, 1900, 0, 0, 2459, 0, 0, 0));
    add_directed(make_sample(0, 2000, 0, 0, 3000, 0, 0, 0));
    add_directed(make_sample(0, 2100, 0, 0, 2000, 0, 0, 0));
    add_directed(make_sample(0, 2200, 0, 0, 3000, -32001, 0, 0));
    add_directed(make_sample(0, 2300, 0, 0, 2000, 0, 0, 0));
    add_directed(make_sample(0, 500, 0, 0, 1000, 0, 0, 0));
    add_directed(make_sample(0, 600, 0, 0, 3000, 0, 0, 0));
    add_directed(make_sample(1, 700, 0, 0, 1000, 0, 0, 0));
    add_directed(make_sample(0, 800, 0, 0, 3000, 0, 0, 0));
    foreach (directed_q[i]) send_sample(directed_q[i]);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      src_idle_pct = (seg < 2) ? 20 : (seg < 4) ? 84 : 0;
      sink_stall_pct = (seg < 2) ? 84 : (seg < 4) ? 20 : 0;
      setting_val[CFG_ACCEL_MIN] = as_reg(-int'($urandom_range(32768, 3000)));
      setting_val[CFG_ACCEL_MAX] = as_reg($urandom_range(32767, 3000));
      setting_val[CFG_GYRO_MIN] = as_reg(-int'($urandom_range(32768, 2000)));
      setting_val[CFG_GYRO_MAX] = as_reg($urandom_range(32767, 2000));
      setting_val[CFG_STEP_THR] = as_reg($urandom_range(3500, 1500));
      setting_val[CFG_MIN_GAP] = as_reg($urandom_range(400, 0));
      setting_val[CFG_MAX_TIME] = as_reg($urandom_range(134217727, 3000000));
      case (seg)
        0: begin
          setting_val[CFG_ACCEL_MIN] = as_reg(-32768);
          setting_val[CFG_ACCEL_MAX] = as_reg(32767);
          setting_val[CFG_GYRO_MIN] = as_reg(-32000);
          setting_val[CFG_GYRO_MAX] = as_reg(32000);
          setting_val[CFG_STEP_THR] = as_reg(2458);
          setting_val[CFG_MIN_GAP] = as_reg(200);
          setting_val[CFG_MAX_TIME] = as_reg(84600000);
        end
        1: begin
          setting_val[CFG_ACCEL_MIN] = as_reg(-32768);
          setting_val[CFG_ACCEL_MAX] = as_reg(32767);
          setting_val[CFG_GYRO_MIN] = as_reg(-32768);
          setting_val[CFG_GYRO_MAX] = as_reg(32767);
          setting_val[CFG_STEP_THR] = as_reg(65535);
          setting_val[CFG_MIN_GAP] = as_reg(0);
          setting_val[CFG_MAX_TIME] = as_reg(134217727);
        end
        3: begin
          setting_val[CFG_GYRO_MIN] = as_reg(2000);
          setting_val[CFG_GYRO_MAX] = as_reg(-2000);
          setting_val[CFG_MAX_TIME] = as_reg(0);
        end
        5: begin
          setting_val[CFG_ACCEL_MIN] = as_reg(-6000);
          setting_val[CFG_ACCEL_MAX] = as_reg(6000);
          setting_val[CFG_GYRO_MIN] = as_reg(-2000);
          setting_val[CFG_GYRO_MAX] = as_reg(2000);
          setting_val[CFG_STEP_THR] = as_reg(0);
          setting_val[CFG_MIN_GAP] = as_reg(65535);
        end
        default: ;
      endcase
      write_settings();

      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ((seg == 0 && n == SEG_ITEMS / 2) || $urandom_range(99) == 0) drain_results();
        r = $urandom_range(99);
        s = '0;
        if (r < 8) begin
          noise = {$urandom, $urandom, $urandom, $urandom};
          s = noise[$bits(in_item_t)-1:0];
        end else begin
          if (r < 11) begin
            walk_time = TIME_W'($urandom_range(2000000, 0));
            s.start_of_run = 1'b1;
          end else if (r < 14) begin
            walk_time = walk_time - TIME_W'($urandom_range(300, 1));
          end else begin
            walk_time = walk_time + TIME_W'($urandom_range(160, 20));
          end
          s.sample_time_ms = walk_time;
          lvl = $urandom_range(1) ? int'($urandom_range(5000, 2600))
                                  : int'($urandom_range(2400, 0));
          s.accel_z = AXIS_W'($urandom_range(1) ? -lvl : lvl);
          s.accel_x = AXIS_W'(int'($urandom_range(1200, 0)) - 600);
          s.accel_y = AXIS_W'(int'($urandom_range(1200, 0)) - 600);
          s.gyro_x = AXIS_W'(int'($urandom_range(3999, 0)) - 2000);
          s.gyro_y = AXIS_W'(int'($urandom_range(3999, 0)) - 2000);
          s.gyro_z = AXIS_W'(int'($urandom_range(3999, 0)) - 2000);
        end
        send_sample(s);
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
    end

    if (fail_count == 0) begin
      $display("imu_step_detector_top: match");
    end else begin
      $display("imu_step_detector_top: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/isd_pkg.sv
design/isd_stream_if.sv
design/isd_ctrl.sv
design/isd_datapath.sv
design/imu_step_detector_top.sv
tb/sv/isd_step_checker.sv
tb/sv/tb_imu_step_detector_top.sv
